// ===== design/bba_pkg.sv =====
// bba_pkg: shared types, constants and codes of the block bitmap allocator
// depends on nothing; imported by every module of the allocator except bba_ram
package bba_pkg;

    // field widths fixed by the request and response formats
    localparam int BLK_W = 14;

    // default geometry of the allocation map
    localparam int DEF_NUM_BITS  = 8192;
    localparam int DEF_WORD_BITS = 32;

    // block limit after reset
    localparam logic [BLK_W-1:0] LIMIT_RESET = BLK_W'(8192);

    // largest value a block limit register can hold
    localparam int LIMIT_MAX = (1 << BLK_W) - 1;

    // request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // response status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // request payload
    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] blk_num;
    } t_req;

    // response payload
    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] allocated_block;
        logic [BLK_W-1:0] free_blocks;
    } t_rsp;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_WR
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    clr_init;
        logic    clr_step;
        logic    scan_init;
        logic    scan_run;
        logic    scan_step;
        logic    free_rd;
        logic    free_wr;
        logic    alloc_wr;
        logic    reply;
        t_status status;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic bno_bad;
        logic lim_zero;
        logic chk_vld;
        logic hit;
        logic chk_last;
    } t_stat;

endpackage

// ===== design/bba_ram.sv =====
// bba_ram: generic single-port-write, single-port-read memory with registered read
// depends on nothing
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_ctrl.sv =====
// bba_ctrl: sequencing state machine of the block bitmap allocator
// depends on bba_pkg; drives bba_dpath through t_cmd and reads t_stat
module bba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_cfg_we,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register, clear sweep runs after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_accept) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.is_free) begin
                    n_state = i_stat.bno_bad ? S_IDLE : S_FREE_WR;
                end else begin
                    n_state = i_stat.lim_zero ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.chk_vld && i_stat.hit) begin
                    n_state = S_ALLOC_WR;
                end else if (i_stat.chk_vld && i_stat.chk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ALLOC_WR: n_state = S_IDLE;
            S_FREE_WR:  n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
        // a limit write restarts the map clear
        if (i_cfg_we) n_state = S_CLEAR;
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.status   = ST_DONE;
        o_cmd.clr_init = i_cfg_we;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
            end
            S_DECIDE: begin
                if (i_stat.is_free) begin
                    if (i_stat.bno_bad) begin
                        o_cmd.reply  = 1'b1;
                        o_cmd.status = ST_INVALID;
                    end else begin
                        o_cmd.free_rd = 1'b1;
                    end
                end else begin
                    if (i_stat.lim_zero) begin
                        o_cmd.reply  = 1'b1;
                        o_cmd.status = ST_NOSPACE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.chk_vld && i_stat.hit) begin
                    o_cmd.scan_step = 1'b0;
                end else if (i_stat.chk_vld && i_stat.chk_last) begin
                    o_cmd.reply  = 1'b1;
                    o_cmd.status = ST_NOSPACE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.alloc_wr = 1'b1;
                o_cmd.reply    = 1'b1;
            end
            S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                o_cmd.reply   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/bba_dpath.sv =====
// bba_dpath: allocation map memory, scan and free logic, counters and result register
// depends on bba_pkg and bba_ram; commanded by bba_ctrl
module bba_dpath #(
    parameter int NUM_BITS  = bba_pkg::DEF_NUM_BITS,
    parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  bba_pkg::t_req            i_req,
    input  logic                     i_cfg_we,
    input  logic [bba_pkg::BLK_W-1:0] i_cfg_wdata,
    input  bba_pkg::t_cmd            i_cmd,
    output bba_pkg::t_stat           o_stat,
    output logic                     o_done,
    output bba_pkg::t_rsp            o_rsp
);
    import bba_pkg::*;

    // map geometry; word width must be a power of two, which the block does not enforce
    localparam int WS        = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [BLK_W-1:0] LIM_CAP   =
        BLK_W'((NUM_BITS > LIMIT_MAX) ? LIMIT_MAX : NUM_BITS);

    logic [BLK_W-1:0]     r_limit;
    logic [BLK_W-1:0]     r_free;
    logic [BLK_W-1:0]     n_free;
    logic                 r_op;
    logic [BLK_W-1:0]     r_bno;
    logic [AW-1:0]        r_clr_word;
    logic [AW-1:0]        r_rd_word;
    logic [AW-1:0]        r_chk_word;
    logic                 r_chk_vld;
    logic [WORD_BITS-1:0] r_wdata;
    logic [BLK_W-1:0]     r_alloc_blk;
    logic                 r_done;
    t_rsp                 r_rsp;

    logic [BLK_W-1:0]     eff_lim;
    logic [BLK_W-1:0]     cfg_eff;
    logic [BLK_W-1:0]     lim_m1;
    logic [AW-1:0]        last_word;
    logic [WS-1:0]        rem;
    logic                 chk_last;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WS-1:0]        hit_pos;
    logic                 hit;
    logic [BLK_W-1:0]     bm1;
    logic [AW-1:0]        free_word;
    logic [WS-1:0]        free_bit;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;

    // effective limits, clamped to the map size
    assign eff_lim = (r_limit > LIM_CAP) ? LIM_CAP : r_limit;
    assign cfg_eff = (i_cfg_wdata > LIM_CAP) ? LIM_CAP : i_cfg_wdata;

    // last word holding a managed block and the last valid bit in it
    assign lim_m1    = eff_lim - BLK_W'(1);
    assign last_word = AW'(lim_m1 >> WS);
    assign rem       = lim_m1[WS-1:0];
    assign chk_last  = (r_chk_word == last_word);

    // mask of managed bits in the word under check
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = !chk_last || (WS'(j) <= rem);
        end
    end

    // lowest clear managed bit
    assign free_bits = ~rd_data & mask;
    assign hit       = |free_bits;
    always_comb begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) hit_pos = WS'(j);
        end
    end

    // word and bit of a block to free
    assign bm1       = r_bno - BLK_W'(1);
    assign free_word = AW'(bm1 >> WS);
    assign free_bit  = bm1[WS-1:0];

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op  <= i_req.op;
            r_bno <= i_req.blk_num;
        end
    end

    // block limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // clear sweep word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_word <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr_word <= '0;
        end else if (i_cmd.clr_step && r_clr_word != LAST_WORD) begin
            r_clr_word <= r_clr_word + AW'(1);
        end
    end

    // scan read and check pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_rd_word <= '0;
        end else if (i_cmd.scan_step) begin
            r_chk_word <= r_rd_word;
            if (r_rd_word != last_word) r_rd_word <= r_rd_word + AW'(1);
        end
    end

    // word with the found bit set and its block number
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run) begin
            r_wdata     <= rd_data | (WORD_BITS'(1) << hit_pos);
            r_alloc_blk <= BLK_W'({r_chk_word, hit_pos}) + BLK_W'(1);
        end
    end

    // memory port selection
    assign ram_raddr = i_cmd.free_rd ? free_word : r_rd_word;
    assign ram_we    = i_cmd.clr_step | i_cmd.alloc_wr | i_cmd.free_wr;
    always_comb begin
        if (i_cmd.clr_step) begin
            ram_waddr = r_clr_word;
            ram_wdata = '0;
        end else if (i_cmd.alloc_wr) begin
            ram_waddr = r_chk_word;
            ram_wdata = r_wdata;
        end else begin
            ram_waddr = free_word;
            ram_wdata = rd_data & ~(WORD_BITS'(1) << free_bit);
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // free block counter, saturating at zero and at the limit
    always_comb begin
        n_free = r_free;
        if (i_cmd.alloc_wr && r_free != '0) begin
            n_free = r_free - BLK_W'(1);
        end else if (i_cmd.free_wr && r_free < eff_lim) begin
            n_free = r_free + BLK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= (LIMIT_RESET > LIM_CAP) ? LIM_CAP : LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_free <= cfg_eff;
        end else begin
            r_free <= n_free;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply) begin
            r_rsp.status          <= i_cmd.status;
            r_rsp.allocated_block <= i_cmd.alloc_wr ? r_alloc_blk : '0;
            r_rsp.free_blocks     <= n_free;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat          = '0;
        o_stat.clr_last = (r_clr_word == LAST_WORD);
        o_stat.is_free  = (r_op == OP_FREE);
        o_stat.bno_bad  = (r_bno == '0) || (r_bno > eff_lim);
        o_stat.lim_zero = (eff_lim == '0);
        o_stat.chk_vld  = r_chk_vld;
        o_stat.hit      = hit;
        o_stat.chk_last = chk_last;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== design/block_bitmap_allocator_unit.sv =====
// block_bitmap_allocator_unit: first-fit block allocator, one request at a time
// a free passes S_DECIDE and S_FREE_WR before the registered result strobe, a rejected
// request only S_DECIDE; an allocate scans in S_SCAN at most W map words up to the
// limit, one per cycle via the read port (W = 256 with defaults), S_ALLOC_WR on a hit;
// busy is high, and no request is taken, while one runs and in the map clear sweep of
// reset and each limit write; results are strobed for one cycle and cannot be stalled
module block_bitmap_allocator_unit #(
    parameter int NUM_BITS  = bba_pkg::DEF_NUM_BITS,
    parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  bba_pkg::t_req             i_req,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::BLK_W-1:0] i_cfg_wdata,
    output logic                      o_done,
    output bba_pkg::t_rsp             o_rsp
);
    import bba_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic  accept;

    // request transfer
    assign accept = start & ~busy;

    bba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg_we (i_cfg_we),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bba_dpath #(
        .NUM_BITS  (NUM_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== design/bba_checker.sv =====
// bba_checker: port-level assertions for block_bitmap_allocator_unit
// depends on bba_pkg; attached to the top level by the bind below
module bba_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          i_cfg_we,
    input logic          o_done,
    input bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    // an accepted request occupies the block in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not make the block busy");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobed without preceding work");

    // failed requests carry no block number
    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_DONE) |-> (o_rsp.allocated_block == '0))
        else $error("failed request returned a block number");

    // a limit write starts the clear sweep
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("limit write did not start the map clear");

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for block_bitmap_allocator_unit, directed and random tests
// depends on bba_pkg and the allocator top level; expected responses come from a local predictor
module testbench;
    import bba_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 8;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    t_req                   i_req       = '0;
    logic                   i_cfg_we    = 1'b0;
    logic [BLK_W-1:0]       i_cfg_wdata = '0;
    logic                   busy;
    logic                   o_done;
    t_rsp                   o_rsp;

    // predictor state: allocation map, free counter and block limit
    bit [DEF_NUM_BITS-1:0]  alloc_map   = '0;
    logic [BLK_W-1:0]       free_count  = LIMIT_RESET;
    logic [BLK_W-1:0]       limit_reg   = LIMIT_RESET;

    t_rsp                   expected_rsps[$];
    t_rsp                   checked_rsp;
    int                     error_count = 0;
    int                     cycle_count = 0;

    block_bitmap_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // limit clamped to the size of the map
    function automatic int usable_blocks();
        return (limit_reg > DEF_NUM_BITS) ? DEF_NUM_BITS : int'(limit_reg);
    endfunction

    // limit write clears the map and reloads the free counter
    function automatic void load_limit(input logic [BLK_W-1:0] value);
        limit_reg  = value;
        alloc_map  = '0;
        free_count = BLK_W'(usable_blocks());
    endfunction

    // first-fit allocate or free, returns the response the block must give
    function automatic t_rsp predict_request(input logic op, input logic [BLK_W-1:0] bno);
        int   lim;
        int   slot;
        bit   found;
        t_rsp r;
        lim               = usable_blocks();
        r.status          = ST_DONE;
        r.allocated_block = '0;
        found             = 1'b0;
        if (op == OP_ALLOC) begin
            for (slot = 0; slot < lim; slot++) begin
                if (!alloc_map[slot]) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                alloc_map[slot] = 1'b1;
                if (free_count > 0)
                    free_count = free_count - 1'b1;
                r.allocated_block = BLK_W'(slot + 1);
            end else begin
                r.status = ST_NOSPACE;
            end
        end else begin
            if (bno == 0 || bno > lim) begin
                r.status = ST_INVALID;
            end else begin
                alloc_map[bno - 1] = 1'b0;
                if (free_count < lim)
                    free_count = free_count + 1'b1;
            end
        end
        r.free_blocks = free_count;
        return r;
    endfunction

    // response checker, oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected response transfer: status %0d block %0d free %0d",
                       o_rsp.status, o_rsp.allocated_block, o_rsp.free_blocks);
                error_count++;
            end else begin
                checked_rsp = expected_rsps.pop_front();
                if (o_rsp.status !== checked_rsp.status) begin
                    $error("status: expected %0d, actual %0d",
                           checked_rsp.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.allocated_block !== checked_rsp.allocated_block) begin
                    $error("allocated_block: expected %0d, actual %0d",
                           checked_rsp.allocated_block, o_rsp.allocated_block);
                    error_count++;
                end
                if (o_rsp.free_blocks !== checked_rsp.free_blocks) begin
                    $error("free_blocks: expected %0d, actual %0d",
                           checked_rsp.free_blocks, o_rsp.free_blocks);
                    error_count++;
                end
            end
        end
    end

    // one request transfer; returns once accepted, start left high
    task automatic send_request(input logic op, input logic [BLK_W-1:0] bno,
                                output t_rsp want);
        start <= 1'b1;
        i_req <= t_req'{op: op, blk_num: bno};
        do @(posedge i_clk); while (busy);
        want = predict_request(op, bno);
        expected_rsps.push_back(want);
    endtask

    // random idle burst on the request side
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // wait for all responses and an idle block
    task automatic wait_drained();
        while (expected_rsps.size() != 0 || busy) @(posedge i_clk);
    endtask

    // limit write, then wait out the clear sweep
    task automatic write_limit(input logic [BLK_W-1:0] value);
        int n;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        load_limit(value);
        i_cfg_we <= 1'b0;
        for (n = 0; n < 4 && !busy; n++) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // reset limit: first fit, bad numbers, double free, top block
    task automatic test_defaults();
        t_rsp r;
        send_request(OP_ALLOC, '0, r);
        send_request(OP_ALLOC, 14'd5, r);
        send_request(OP_FREE, 14'd0, r);
        send_request(OP_FREE, 14'd8193, r);
        send_request(OP_FREE, 14'd16383, r);
        send_request(OP_FREE, 14'd1, r);
        send_request(OP_FREE, 14'd1, r);
        send_request(OP_ALLOC, 14'd16383, r);
        send_request(OP_FREE, 14'd8192, r);
        start <= 1'b0;
    endtask

    // zero limit manages nothing
    task automatic test_zero_limit();
        t_rsp r;
        write_limit(14'd0);
        send_request(OP_ALLOC, '0, r);
        send_request(OP_FREE, 14'd1, r);
        send_request(OP_FREE, 14'd0, r);
        start <= 1'b0;
    endtask

    // one block: fill, no space, free, reuse
    task automatic test_single_block();
        t_rsp r;
        write_limit(14'd1);
        send_request(OP_ALLOC, '0, r);
        send_request(OP_ALLOC, '0, r);
        send_request(OP_FREE, 14'd2, r);
        send_request(OP_FREE, 14'd1, r);
        send_request(OP_ALLOC, '0, r);
        start <= 1'b0;
    endtask

    // limit above the map size is clamped
    task automatic test_clamped_limit();
        t_rsp r;
        write_limit(14'd16383);
        send_request(OP_FREE, 14'd8192, r);
        send_request(OP_FREE, 14'd8193, r);
        send_request(OP_ALLOC, '0, r);
        send_request(OP_ALLOC, '0, r);
        start <= 1'b0;
    endtask

    // mostly allocate / free of held blocks, some bad or stray frees
    task automatic run_traffic(input logic [BLK_W-1:0] limit, input int count,
                               input bit allow_idle);
        int               held[$];
        int               k;
        int               pick;
        int               lim;
        logic             op;
        logic [BLK_W-1:0] bno;
        t_rsp             r;
        write_limit(limit);
        lim = usable_blocks();
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            op   = OP_ALLOC;
            bno  = BLK_W'($urandom_range(0, LIMIT_MAX));
            if (pick >= 55 && pick < 85 && held.size() != 0) begin
                op   = OP_FREE;
                pick = $urandom_range(0, held.size() - 1);
                bno  = BLK_W'(held[pick]);
                held.delete(pick);
            end else if (pick >= 85) begin
                op = OP_FREE;
                case ($urandom_range(0, 4))
                    0: bno = '0;
                    1: bno = BLK_W'(lim + $urandom_range(0, 2));
                    2: bno = BLK_W'($urandom_range(1, (lim > 0) ? lim : 1));
                    default: ;
                endcase
            end
            send_request(op, bno, r);
            if (op == OP_ALLOC && r.status == ST_DONE)
                held.push_back(int'(r.allocated_block));
            maybe_idle(allow_idle && ((k / 32) % 2 == 0));
        end
        start <= 1'b0;
    endtask

    // random phases over several limits, word boundaries and full maps
    task automatic test_random_traffic();
        run_traffic(14'd8192, 150, 1'b1);
        run_traffic(14'd40, 150, 1'b1);
        run_traffic(14'd5, 80, 1'b1);
        run_traffic(14'd33, 150, 1'b1);
        run_traffic(14'd1, 40, 1'b1);
        run_traffic(14'd64, 150, 1'b1);
        run_traffic(14'd16383, 100, 1'b1);
        run_traffic(14'd300, 150, 1'b1);
    endtask

    // back-to-back requests with no idle cycles
    task automatic test_steady_stream();
        run_traffic(14'd100, 150, 1'b0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);
        test_defaults();
        test_zero_limit();
        test_single_block();
        test_clamped_limit();
        test_random_traffic();
        test_steady_stream();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
